// ----- rtl/a85_pkg.sv -----
// a85_pkg: shared types, character codes and tables for the ascii85 stream decoder
// no dependencies; used by a85_decode, a85_serial, the top level and the checker

package a85_pkg;

  // decoder phase within one string
  typedef enum logic [1:0] {
    PH_RUN = 2'd0,
    PH_END = 2'd1,
    PH_ERR = 2'd2
  } phase_t;

  // result kind codes as seen on the result channel
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // character codes
  localparam logic [7:0] CH_FIRST = 8'h21;  // '!'
  localparam logic [7:0] CH_LAST  = 8'h75;  // 'u'
  localparam logic [7:0] CH_ZERO  = 8'h7A;  // 'z'
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // results of one decoded character: data bytes first, then an optional marker
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[3] goes out first
    logic [2:0]      data_cnt;  // 0 to 4 data bytes
    logic            tail;      // end or error marker follows the data
    kind_t           tail_kind;
  } a85_grp_t;

  // base-85 digit weight by position in the group
  function automatic logic [31:0] weight85(input logic [2:0] pos);
    logic [31:0] w;
    case (pos)
      3'd0:    w = 32'd52200625;
      3'd1:    w = 32'd614125;
      3'd2:    w = 32'd7225;
      3'd3:    w = 32'd85;
      default: w = 32'd1;
    endcase
    return w;
  endfunction

  // whitespace and control characters that are skipped
  function automatic logic is_ignored(input logic [7:0] c);
    logic r;
    case (c)
      CH_NUL, CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE, CH_DEL: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/a85_stream_if.sv -----
// a85_stream_if: valid/ready channel interfaces for characters and results
// depends on nothing; used by the decoder modules and the top level

interface a85_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       start_of_string;

  modport source (output valid, output in_char, output start_of_string, input ready);
  modport sink   (input valid, input in_char, input start_of_string, output ready);
endinterface

interface a85_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ----- rtl/a85_decode.sv -----
// a85_decode: input register, decoder state and single-pass character decode
// depends on a85_pkg and a85_char_if; feeds result groups to a85_serial

module a85_decode
  import a85_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  a85_char_if.sink      chars,
  input  logic          buf_free,
  output logic          grp_load,
  output a85_grp_t      grp
);

  // input register
  logic       in_v;
  logic [7:0] c_q;
  logic       sos_q;

  // decoder state
  logic [31:0] acc;
  logic [2:0]  cnt;
  logic        tp;
  phase_t      ph;

  logic [31:0] acc_e, acc_next, addend, prod, sum;
  logic [2:0]  cnt_e, cnt_next, pos;
  logic        tp_e, tp_next;
  phase_t      ph_e, ph_next;
  logic [6:0]  digit;
  logic        has_res, fire;

  // state as seen by this character, after an optional restart
  always_comb begin
    acc_e = sos_q ? 32'd0 : acc;
    cnt_e = sos_q ? 3'd0 : cnt;
    tp_e  = sos_q ? 1'b0 : tp;
    ph_e  = sos_q ? PH_RUN : ph;
  end

  // shared adder: digit product, or the flush unit at the last position
  always_comb begin
    pos    = (cnt_e > 3'd4) ? 3'd4 : cnt_e;
    digit  = c_q[6:0] - CH_FIRST[6:0];
    prod   = {25'd0, digit} * weight85(pos);
    addend = tp_e ? weight85(3'(cnt_e - 3'd1)) : prod;
    sum    = acc_e + addend;
  end

  // decode one character
  always_comb begin
    acc_next      = acc_e;
    cnt_next      = cnt_e;
    tp_next       = tp_e;
    ph_next       = ph_e;
    grp.bytes     = '0;
    grp.data_cnt  = 3'd0;
    grp.tail      = 1'b0;
    grp.tail_kind = KIND_DATA;
    if (ph_e == PH_RUN) begin
      if (tp_e) begin
        tp_next = 1'b0;
        if (c_q == CH_GT) begin
          if (cnt_e != 3'd0) begin
            grp.bytes    = sum;
            grp.data_cnt = 3'(cnt_e - 3'd1);
          end
          acc_next      = 32'd0;
          cnt_next      = 3'd0;
          ph_next       = PH_END;
          grp.tail      = 1'b1;
          grp.tail_kind = KIND_END;
        end
      end else if (c_q == CH_ZERO) begin
        if (cnt_e != 3'd0) begin
          ph_next       = PH_ERR;
          grp.tail      = 1'b1;
          grp.tail_kind = KIND_ERR;
        end else begin
          grp.data_cnt = 3'd4;
        end
      end else if (c_q == CH_TILDE) begin
        tp_next = 1'b1;
      end else if (is_ignored(c_q)) begin
        tp_next = 1'b0;
      end else if (c_q inside {[CH_FIRST:CH_LAST]}) begin
        if (pos == 3'd4) begin
          grp.bytes    = sum;
          grp.data_cnt = 3'd4;
          acc_next     = 32'd0;
          cnt_next     = 3'd0;
        end else begin
          acc_next = sum;
          cnt_next = pos + 3'd1;
        end
      end else begin
        ph_next       = PH_ERR;
        grp.tail      = 1'b1;
        grp.tail_kind = KIND_ERR;
      end
    end
  end

  // handshake: a character with no results never waits for the buffer
  assign has_res     = (grp.data_cnt != 3'd0) || grp.tail;
  assign fire        = in_v && (buf_free || !has_res);
  assign grp_load    = fire && has_res;
  assign chars.ready = !in_v || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (chars.ready) begin
      in_v <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      c_q   <= chars.in_char;
      sos_q <= chars.start_of_string;
    end
  end

  // decoder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
      cnt <= 3'd0;
      tp  <= 1'b0;
      ph  <= PH_RUN;
    end else if (fire) begin
      acc <= acc_next;
      cnt <= cnt_next;
      tp  <= tp_next;
      ph  <= ph_next;
    end
  end

endmodule

// ----- rtl/a85_serial.sv -----
// a85_serial: result register that sends a decoded group one result per cycle while the receiver is ready
// depends on a85_pkg and a85_result_if; loaded by a85_decode

module a85_serial
  import a85_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          grp_load,
  input  a85_grp_t      grp,
  output logic          buf_free,
  a85_result_if.source  results
);

  logic       busy;
  logic [1:0] idx;
  a85_grp_t   g;
  logic [2:0] total;
  logic       is_last, is_data, fire;

  // position within the group
  always_comb begin
    total   = g.data_cnt + {2'd0, g.tail};
    is_last = ({1'b0, idx} == 3'(total - 3'd1));
    is_data = ({1'b0, idx} < g.data_cnt);
    fire    = busy && results.ready;
  end

  // result channel
  assign results.valid    = busy;
  assign results.out_byte = is_data ? g.bytes[2'(2'd3 - idx)] : 8'd0;
  assign results.kind     = is_data ? KIND_DATA : g.tail_kind;
  assign results.last     = is_last;
  assign buf_free         = !busy || (results.ready && is_last);

  // occupancy and index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (grp_load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (fire) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // group payload
  always_ff @(posedge clk) begin
    if (grp_load) begin
      g <= grp;
    end
  end

endmodule

// ----- rtl/ascii85_stream_decoder_unit.sv -----
// ascii85_stream_decoder_unit: top level of the streaming ascii85 decoder
// depends on a85_pkg, a85_stream_if, a85_decode and a85_serial
//
// Usage: one character enters per transaction on the chars channel; set
// start_of_string on the first character of a string to clear the decoder.
// The results channel carries decoded bytes (kind 0), the end marker after
// "~>" (kind 1) or a decode error (kind 2); last marks the final result that
// a character causes. After an end marker or error nothing more is produced
// until the next start_of_string.
// The first result of a character passes the input register, then the result
// register, before it can be taken on the results channel.
// Throughput: one character per cycle when it yields at most one result and
// the receiver does not stall; a completed group or 'z' yields four results,
// which the one-byte result register sends one at a time.
// The next character is decoded in the cycle the last result is taken.
// Reset clears the input register, the accumulator, digit count, pending
// tilde and phase, and drops any result not yet sent. While the receiver
// stalls the result is held; characters with no results still pass; the
// first with results waits in the input register while chars.ready is low.

module ascii85_stream_decoder_unit
  import a85_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  a85_char_if.sink     chars,
  a85_result_if.source results
);

  logic     buf_free;
  logic     grp_load;
  a85_grp_t grp;

  // character decode
  a85_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .buf_free (buf_free),
    .grp_load (grp_load),
    .grp      (grp)
  );

  // result serialiser
  a85_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .grp_load (grp_load),
    .grp      (grp),
    .buf_free (buf_free),
    .results  (results)
  );

endmodule

// ----- rtl/a85_checker.sv -----
// a85_checker: port-level assertions for the ascii85 decoder top level
// depends on a85_pkg; bound to ascii85_stream_decoder_unit below

module a85_checker
  import a85_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_byte,
  input logic [1:0] res_kind,
  input logic       res_last
);

  // no kind code beyond error
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_kind == KIND_DATA || res_kind == KIND_END || res_kind == KIND_ERR))
    else $error("undefined result kind");

  // markers carry a zero byte and close their character's results
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_kind != KIND_DATA) |-> (res_last && res_byte == 8'd0))
    else $error("marker result not last or byte not zero");

  // the rest of a group follows without a gap
  a_group_contiguous: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && !res_last) |=> res_valid)
    else $error("gap inside a result group");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_byte) && $stable(res_kind) && $stable(res_last)))
    else $error("stalled result changed");

endmodule

bind ascii85_stream_decoder_unit a85_checker u_a85_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_byte  (results.out_byte),
  .res_kind  (results.kind),
  .res_last  (results.last)
);
